// ----- sv/adm_pkg.sv -----
// shared types and constants of the addressed message deframer
`default_nettype none

package adm_pkg;

    // message buffer size and derived widths
    localparam int MSG_CAP = 64;
    localparam int IDX_W   = $clog2(MSG_CAP);

    // id accumulator saturates at one past the largest target
    localparam int          ID_W   = 17;
    localparam logic [ID_W-1:0] ID_SAT = 17'h10000;

    // framing characters
    localparam logic [7:0] CHAR_OPEN  = 8'h3C;
    localparam logic [7:0] CHAR_AT    = 8'h40;
    localparam logic [7:0] CHAR_CLOSE = 8'h3E;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    // command queue depth
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // configuration register indexes
    localparam logic CFG_FILTER_ENABLE = 1'b0;
    localparam logic CFG_TARGET_ID     = 1'b1;

    // parser phase
    typedef enum logic [1:0] {
        PH_WAIT,
        PH_ID,
        PH_MSG
    } phase_t;

    // commands from the parser to the emitter
    typedef enum logic [1:0] {
        OP_PASS,
        OP_STORE,
        OP_STORE_EMIT,
        OP_EMIT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t          op;
        logic [7:0]       data;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // emitter state
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SEND
    } bk_state_t;

endpackage

`default_nettype wire

// ----- sv/adm_front.sv -----
// parser: classifies each item and issues one command per item at most
`default_nettype none

module adm_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      rx_byte,
    input  wire logic            filter_enable,
    input  wire logic [15:0]     target_id,
    output logic                 push,
    output adm_pkg::cmd_t        cmd
);
    import adm_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    logic             is_digit;
    logic [19:0]      id_prod;
    logic             id_match;
    logic             buf_full;

    // id times ten plus digit, and frame checks
    assign is_digit = (rx_byte inside {[CHAR_ZERO:CHAR_NINE]});
    assign id_prod  = ({3'b000, id_reg} << 3) + ({3'b000, id_reg} << 1)
                    + {16'h0000, rx_byte[3:0] - CHAR_ZERO[3:0]};
    assign id_match = (id_reg == {1'b0, target_id});
    assign buf_full = (cnt_reg >= IDX_W'(MSG_CAP - 2));

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        id_next    = id_reg;
        cnt_next   = cnt_reg;
        if (accept && filter_enable)
        begin
            case (phase_reg)
                PH_ID:
                begin
                    if (is_digit)
                    begin
                        id_next = (id_prod >= 20'(ID_SAT)) ? ID_SAT : id_prod[ID_W-1:0];
                    end
                    else if (rx_byte == CHAR_AT)
                    begin
                        phase_next = PH_MSG;
                    end
                    else
                    begin
                        phase_next = PH_WAIT;
                    end
                end
                PH_MSG:
                begin
                    if (!id_match)
                    begin
                        phase_next = PH_WAIT;
                    end
                    else if (rx_byte == CHAR_CLOSE || buf_full)
                    begin
                        phase_next = PH_WAIT;
                        id_next    = '0;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    id_next    = '0;
                    cnt_next   = '0;
                    phase_next = (rx_byte == CHAR_OPEN) ? PH_ID : PH_WAIT;
                end
            endcase
        end
    end

    // command issue
    always_comb
    begin
        push     = 1'b0;
        cmd.op   = OP_PASS;
        cmd.data = rx_byte;
        cmd.idx  = cnt_reg;
        if (accept)
        begin
            if (!filter_enable)
            begin
                push = 1'b1;
            end
            else if (phase_reg == PH_MSG && id_match)
            begin
                push = 1'b1;
                if (rx_byte == CHAR_CLOSE)
                begin
                    cmd.op = OP_EMIT;
                end
                else if (buf_full)
                begin
                    cmd.op = OP_STORE_EMIT;
                end
                else
                begin
                    cmd.op = OP_STORE;
                end
            end
        end
    end

    // parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            id_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            id_reg    <= id_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/adm_queue.sv -----
// short command queue between parser and emitter
`default_nettype none

module adm_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire adm_pkg::cmd_t  push_cmd,
    input  wire logic           pop,
    output adm_pkg::cmd_t       head_cmd,
    output adm_pkg::q_stat_t    stat
);
    import adm_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;

    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign stat.full  = (fill_reg == (QPTR_W+1)'(QDEPTH));
    assign stat.empty = (fill_reg == '0);

    // storage slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/adm_back.sv -----
// emitter: message buffer, drain sequencer and output register
`default_nettype none

module adm_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire adm_pkg::cmd_t    head_cmd,
    input  wire adm_pkg::q_stat_t q_stat,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [7:0]            out_byte,
    output logic                  last,
    output logic                  empty_message,
    output logic                  passthrough
);
    import adm_pkg::*;

    logic [7:0]       msg_mem [MSG_CAP];
    logic [7:0]       rd_data_reg;

    bk_state_t        state_reg, state_next;
    logic [IDX_W-1:0] drain_idx_reg;
    logic [IDX_W-1:0] drain_last_reg;

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             last_reg;
    logic             empty_reg;
    logic             pass_reg;

    logic             out_free;
    logic             mem_we;
    logic             load;
    logic [7:0]       ld_byte;
    logic             ld_last;
    logic             ld_empty;
    logic             ld_pass;
    logic             drain_start;
    logic             drain_step;
    logic             drain_end;
    logic [IDX_W-1:0] start_last;

    assign out_free  = !out_valid_reg || !out_stall;
    assign drain_end = (drain_idx_reg == drain_last_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (drain_start)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                state_next = BK_SEND;
            end
            BK_SEND:
            begin
                if (out_free)
                begin
                    state_next = drain_end ? BK_IDLE : BK_READ;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // command execution and output loading
    always_comb
    begin
        pop         = 1'b0;
        mem_we      = 1'b0;
        load        = 1'b0;
        ld_byte     = '0;
        ld_last     = 1'b0;
        ld_empty    = 1'b0;
        ld_pass     = 1'b0;
        drain_start = 1'b0;
        drain_step  = 1'b0;
        start_last  = head_cmd.idx;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty && out_free)
                begin
                    pop = 1'b1;
                    case (head_cmd.op)
                        OP_PASS:
                        begin
                            load    = 1'b1;
                            ld_byte = head_cmd.data;
                            ld_last = 1'b1;
                            ld_pass = 1'b1;
                        end
                        OP_STORE:
                        begin
                            mem_we = 1'b1;
                        end
                        OP_STORE_EMIT:
                        begin
                            mem_we      = 1'b1;
                            drain_start = 1'b1;
                        end
                        OP_EMIT:
                        begin
                            if (head_cmd.idx == '0)
                            begin
                                load     = 1'b1;
                                ld_last  = 1'b1;
                                ld_empty = 1'b1;
                            end
                            else
                            begin
                                drain_start = 1'b1;
                                start_last  = head_cmd.idx - 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BK_SEND:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    ld_byte    = rd_data_reg;
                    ld_last    = drain_end;
                    drain_step = !drain_end;
                end
            end
            default:
            begin
            end
        endcase
    end

    // message buffer with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            msg_mem[head_cmd.idx] <= head_cmd.data;
        end
        rd_data_reg <= msg_mem[drain_idx_reg];
    end

    // drain counters and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            drain_idx_reg  <= '0;
            drain_last_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (drain_start)
            begin
                drain_idx_reg  <= '0;
                drain_last_reg <= start_last;
            end
            else if (drain_step)
            begin
                drain_idx_reg <= drain_idx_reg + 1'b1;
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= load;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_free && load)
        begin
            out_byte_reg <= ld_byte;
            last_reg     <= ld_last;
            empty_reg    <= ld_empty;
            pass_reg     <= ld_pass;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign last          = last_reg;
    assign empty_message = empty_reg;
    assign passthrough   = pass_reg;

endmodule

`default_nettype wire

// ----- sv/addressed_message_deframer_unit.sv -----
// top level of the addressed message deframer
//
// Input channel: in_valid / in_stall carry one received byte (rx_byte) per item.
// Output channel: out_valid / out_stall carry one result item: out_byte, last,
// empty_message, passthrough. Configuration: cfg_we writes cfg_wdata to the
// register at cfg_index (0 filter_enable, 1 target_id), one write per edge.
// With filtering off every byte comes back with last and passthrough set,
// via the queue and the output register. With filtering on, frames '<' id '@' msg '>'
// whose id equals target_id are delivered as message bytes, the final one
// marked last; an empty message gives a single item with empty_message set.
// The parser takes one byte per cycle while its four-entry command queue has
// room. The emitter reads the 64-byte message buffer through one registered
// read port, so each message byte passes a read state and then a send state;
// in_stall rises once the queue fills.
// Reset clears the parser to waiting for '<', empties the queue and output,
// and sets both registers to zero; the buffer needs no clearing pass.
// While out_stall is high and out_valid is set, the output item holds and the emitter waits.
`default_nettype none

module addressed_message_deframer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             last,
    output logic             empty_message,
    output logic             passthrough,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    import adm_pkg::*;

    logic        filter_enable_reg;
    logic [15:0] target_id_reg;

    logic        accept;
    logic        f_push;
    cmd_t        f_cmd;
    cmd_t        head_cmd;
    q_stat_t     q_stat;
    logic        b_pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg <= 1'b0;
            target_id_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FILTER_ENABLE: filter_enable_reg <= cfg_wdata[0];
                CFG_TARGET_ID:     target_id_reg     <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // input handshake
    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;

    adm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .rx_byte       (rx_byte),
        .filter_enable (filter_enable_reg),
        .target_id     (target_id_reg),
        .push          (f_push),
        .cmd           (f_cmd)
    );

    adm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_push),
        .push_cmd (f_cmd),
        .pop      (b_pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    adm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_cmd      (head_cmd),
        .q_stat        (q_stat),
        .pop           (b_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .last          (last),
        .empty_message (empty_message),
        .passthrough   (passthrough)
    );

    // queue never written when full nor read when empty
    assert property (@(posedge clk) disable iff (!rst_n) q_stat.full |-> !f_push)
        else $error("command pushed into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) q_stat.empty |-> !b_pop)
        else $error("command popped from empty queue");

    // result marks are consistent
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && empty_message) |-> (last && !passthrough && out_byte == 8'h00))
        else $error("empty message item malformed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && passthrough) |-> (last && !empty_message))
        else $error("passthrough item malformed");

endmodule

`default_nettype wire

// ----- tb/sv/tb_addressed_message_deframer_unit.sv -----
// testbench for the addressed message deframer: random framed traffic checked against a predictor
module tb_addressed_message_deframer_unit;
    import adm_pkg::*;

    localparam int SETTLE     = 150;
    localparam int IDLE_LIMIT = 4000;

    // one result item as the block presents it
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
        logic       pass;
    } deframed_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        last;
    logic        empty_message;
    logic        passthrough;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_FILTER_ENABLE;
    logic [15:0] cfg_wdata = 16'h0000;

    // bytes waiting to be sent and message characters still to come back
    logic [7:0]  tx_bytes[$];
    deframed_t   due_chars[$];
    deframed_t   head_item;
    int          queued_cnt = 0;
    int          mismatch_cnt = 0;

    // handshake bookkeeping of both sides
    logic        in_fired = 1'b0;
    int          in_gap = 0;
    int          out_wait = 0;
    int          run_left[2] = '{0, 0};
    bit          calm_run[2] = '{0, 0};
    int          idle_cycles = 0;

    // predictor copy of the registers and the parser
    logic        flt_en = 1'b0;
    logic [15:0] tgt_id = 16'h0000;
    phase_t      ph = PH_WAIT;
    logic [16:0] id_acc = '0;
    logic [7:0]  msg_buf[MSG_CAP];
    logic [6:0]  msg_cnt = '0;

    addressed_message_deframer_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .last          (last),
        .empty_message (empty_message),
        .passthrough   (passthrough),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // wait length for the next item, in stretches that are either busy or calm
    function automatic int draw_wait(input int side);
        if (run_left[side] == 0)
        begin
            run_left[side] = $urandom_range(4, 24);
            calm_run[side] = ($urandom_range(0, 2) == 0);
        end
        run_left[side]--;
        return calm_run[side] ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic void add_due(input logic [7:0] data, input logic lst,
                                    input logic emp, input logic pas);
        deframed_t item;
        item.data  = data;
        item.last  = lst;
        item.empty = emp;
        item.pass  = pas;
        due_chars.push_back(item);
    endfunction

    // buffered message goes out; an empty one gives a single marked item
    function automatic void release_message();
        if (msg_cnt == 0)
            add_due(8'h00, 1'b1, 1'b1, 1'b0);
        else
            for (int i = 0; i < msg_cnt; i++)
                add_due(msg_buf[i], (i == msg_cnt - 1), 1'b0, 1'b0);
        ph      = PH_WAIT;
        msg_cnt = '0;
        id_acc  = '0;
    endfunction

    // parser step for one accepted byte
    function automatic void deframe_byte(input logic [7:0] c);
        int unsigned acc;
        if (!flt_en)
        begin
            add_due(c, 1'b1, 1'b0, 1'b1);
            return;
        end
        case (ph)
            PH_ID:
            begin
                if (c >= CHAR_ZERO && c <= CHAR_NINE)
                begin
                    acc    = id_acc * 32'd10 + (c - CHAR_ZERO);
                    id_acc = (acc >= ID_SAT) ? ID_SAT : acc[16:0];
                end
                else if (c == CHAR_AT)
                    ph = PH_MSG;
                else
                    ph = PH_WAIT;
            end
            PH_MSG:
            begin
                // a wrong id drops the frame on the first message byte
                if (id_acc != {1'b0, tgt_id})
                    ph = PH_WAIT;
                else if (c == CHAR_CLOSE)
                    release_message();
                else
                begin
                    if (msg_cnt < MSG_CAP)
                    begin
                        msg_buf[msg_cnt] = c;
                        msg_cnt++;
                    end
                    if (msg_cnt >= MSG_CAP - 1)
                        release_message();
                end
            end
            default:
            begin
                id_acc  = '0;
                msg_cnt = '0;
                ph      = (c == CHAR_OPEN) ? PH_ID : PH_WAIT;
            end
        endcase
    endfunction

    // input side: predict on acceptance
    always @(posedge clk)
    begin
        in_fired <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            deframe_byte(rx_byte);
            in_gap = draw_wait(0);
        end
    end

    // input side: present the next item after its gap
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fired))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (tx_bytes.size() != 0)
            begin
                in_valid <= 1'b1;
                rx_byte  <= tx_bytes.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output side: compare each accepted item with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_chars.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected item: out_byte %02h last %0d empty %0d pass %0d",
                             out_byte, last, empty_message, passthrough);
            end
            else
            begin
                head_item = due_chars.pop_front();
                if (out_byte !== head_item.data || last !== head_item.last ||
                    empty_message !== head_item.empty || passthrough !== head_item.pass)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: got %02h/%0d/%0d/%0d expected %02h/%0d/%0d/%0d",
                                 out_byte, last, empty_message, passthrough,
                                 head_item.data, head_item.last, head_item.empty,
                                 head_item.pass);
                end
            end
            out_wait = draw_wait(1);
        end
    end

    // output side: stall each item for its drawn number of cycles
    always @(negedge clk)
    begin
        if (out_valid && out_wait > 0)
        begin
            out_wait--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_addressed_message_deframer_unit failed");
                $finish;
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        queued_cnt++;
    endtask

    // '<', optional leading zeros, decimal id, '@', message, optional '>'
    task automatic queue_frame(input longint id, input int zeros, input int len,
                               input bit close);
        logic [7:0] digs[$];
        logic [7:0] ch;
        longint     v;
        v = id;
        queue_byte(CHAR_OPEN);
        repeat (zeros) queue_byte(CHAR_ZERO);
        while (v > 0)
        begin
            digs.push_front(8'(v % 10) + CHAR_ZERO);
            v = v / 10;
        end
        foreach (digs[i]) queue_byte(digs[i]);
        queue_byte(CHAR_AT);
        repeat (len)
        begin
            do ch = 8'($urandom_range(0, 255)); while (ch == CHAR_CLOSE);
            queue_byte(ch);
        end
        if (close)
            queue_byte(CHAR_CLOSE);
    endtask

    // mostly matching frames, with wrong ids, oversized ids, broken frames and noise
    task automatic queue_traffic(input int unsigned tgt, input int budget);
        int         stop;
        int         kind;
        logic [7:0] junk;
        stop = queued_cnt + budget;
        while (queued_cnt < stop)
        begin
            kind = $urandom_range(0, 11);
            if (kind <= 6)
                queue_frame(tgt, $urandom_range(0, 2), $urandom_range(0, 8), 1'b1);
            else if (kind == 7)
                queue_frame((tgt + $urandom_range(1, 65535)) % 65536, 0,
                            $urandom_range(0, 4), 1'b1);
            else if (kind == 8)
                queue_frame(65536 + $urandom_range(0, 2000000), 0, $urandom_range(0, 3), 1'b1);
            else if (kind == 9)
            begin
                queue_byte(CHAR_OPEN);
                repeat ($urandom_range(0, 3)) queue_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
                do junk = 8'($urandom_range(0, 255));
                while ((junk >= CHAR_ZERO && junk <= CHAR_NINE) || junk == CHAR_AT);
                if ($urandom_range(0, 1))
                    junk = CHAR_OPEN;
                queue_byte(junk);
            end
            else if (kind == 10)
                queue_frame(tgt, 0, $urandom_range(0, 5), 1'b0);
            else
                repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // all sent and all results back
    task automatic wait_drained();
        do @(posedge clk);
        while (tx_bytes.size() != 0 || in_valid || due_chars.size() != 0);
        @(negedge clk);
    endtask

    task automatic wait_settled();
        wait_drained();
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == CFG_FILTER_ENABLE)
            flt_en = val[0];
        else
            tgt_id = val;
    endtask

    // stimulus
    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // passthrough after reset
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(CHAR_OPEN);
        queue_byte(8'hA5);
        wait_settled();

        write_reg(CFG_FILTER_ENABLE, 16'd1);
        write_reg(CFG_TARGET_ID, 16'hFFFF);

        // empty message, bad id characters, wrong id, frame left open
        queue_frame(65535, 0, 0, 1'b1);
        queue_byte(CHAR_OPEN);
        queue_byte(8'h31);
        queue_byte(8'h78);
        queue_byte(CHAR_OPEN);
        queue_byte(CHAR_OPEN);
        queue_frame(7, 0, 0, 1'b0);
        queue_byte(8'h5A);
        queue_frame(0, 1, 0, 1'b0);
        wait_settled();

        // target changes while a frame for id zero is open
        write_reg(CFG_TARGET_ID, 16'h0000);
        queue_byte(8'h71);
        queue_byte(CHAR_CLOSE);

        // full buffer, oversized id, then mixed traffic with a full drain between
        queue_frame(0, 0, $urandom_range(61, 66), 1'b1);
        queue_frame(65536, 0, 2, 1'b1);
        queue_traffic(0, 12);
        wait_drained();
        queue_traffic(0, 10);
        wait_settled();

        write_reg(CFG_TARGET_ID, 16'($urandom_range(1, 65534)));
        queue_traffic(tgt_id, 16);
        wait_settled();

        // passthrough again with the parser state kept
        write_reg(CFG_FILTER_ENABLE, 16'd0);
        write_reg(CFG_TARGET_ID, 16'hFFFF);
        repeat (16) queue_byte(8'($urandom_range(0, 255)));
        wait_settled();

        write_reg(CFG_FILTER_ENABLE, 16'd1);
        queue_traffic(65535, 12);

        wait_settled();
        if (mismatch_cnt == 0)
            $display("tb_addressed_message_deframer_unit passed");
        else
            $display("tb_addressed_message_deframer_unit failed");
        $finish;
    end

endmodule
